>>> sv/saa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

    localparam int SAA_MAX_WIDTH      = 1024;
    localparam int SAA_COEF_FRAC_BITS = 16;

    localparam int PIX_W        = 8;
    localparam int COEF_W       = 18;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 18;
    localparam int MAX_HEIGHT   = 4096;

    localparam int S_TDATA_W = 3 * PIX_W;
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - ROW_W - COL_W - 3 * PIX_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BR      = 3'd5;

    localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic [COEF_W-1:0]       RST_COEF_TL      = 18'd65536;
    localparam logic [COEF_W-1:0]       RST_COEF_OTHER   = 18'd0;

    // red in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] tl;
        logic signed [COEF_W-1:0] tr;
        logic signed [COEF_W-1:0] bl;
        logic signed [COEF_W-1:0] br;
    } coef_set_t;

    typedef struct packed {
        pixel_t           tl;
        pixel_t           tr;
        pixel_t           bl;
        pixel_t           br;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } tap_set_t;

endpackage

`default_nettype wire

>>> sv/supersample_antialias_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: red, green, blue
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: red, green, blue, column, row;
//                                                    tlast: last result of the input pixel
// cfg       in         cfg_wen (no wait)             cfg_index, cfg_wdata
//
// one pixel per clock when a pixel makes at most one result and the output is not stalled;
// a pixel that makes k results holds the input stage until its last result issues, since the
// tap sequencer issues one result per cycle while the output is not stalled. results pass the
// input stage (line store read with it), taps, products, sum/saturate into the output register.
// synchronous active-low reset clears control, counters and neighbor pixels, not the line store.
// a stalled output backs up stage by stage; input is still taken into a free input stage.

module supersample_antialias_filter #(
    parameter int MAX_WIDTH      = saa_pkg::SAA_MAX_WIDTH,
    parameter int COEF_FRAC_BITS = saa_pkg::SAA_COEF_FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [saa_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // red, green, blue
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [saa_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // red, green, blue, out_column, out_row
    output logic                             m_axis_tlast,
    input  logic                             cfg_wen,
    input  logic [saa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [saa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import saa_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    coef_set_t               coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            coef_reg.tl <= RST_COEF_TL;
            coef_reg.tr <= RST_COEF_OTHER;
            coef_reg.bl <= RST_COEF_OTHER;
            coef_reg.br <= RST_COEF_OTHER;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg   <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_wdata[HEIGHT_REG_W-1:0];
                REG_COEF_TL:      coef_reg.tl <= cfg_wdata[COEF_W-1:0];
                REG_COEF_TR:      coef_reg.tr <= cfg_wdata[COEF_W-1:0];
                REG_COEF_BL:      coef_reg.bl <= cfg_wdata[COEF_W-1:0];
                REG_COEF_BR:      coef_reg.br <= cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [EW-1:0]           width_ext;
    logic [EW-1:0]           width_eff;
    logic [HEIGHT_REG_W-1:0] height_eff;

    always_comb begin
        width_ext = EW'(width_reg);
        if (width_ext == '0) begin
            width_eff = EW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_reg == '0) begin
            height_eff = HEIGHT_REG_W'(1);
        end else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            height_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_reg;
        end
    end

    // position of the next input pixel
    logic [CW-1:0]    col_cnt_reg;
    logic [ROW_W-1:0] row_cnt_reg;
    logic             last_col;
    logic             last_row;
    logic             s_acc;
    pixel_t           s_px;

    assign s_px     = pixel_t'(s_axis_tdata);
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign last_col = EW'(col_cnt_reg) >= width_eff - EW'(1);
    assign last_row = {1'b0, row_cnt_reg} >= height_eff - HEIGHT_REG_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_acc) begin
            if (last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // line store, read before write at the same column
    pixel_t line_mem [MAX_WIDTH];
    pixel_t above_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            above_reg              <= line_mem[col_cnt_reg];
            line_mem[col_cnt_reg]  <= s_px;
        end
    end

    // input stage: pixel plus mask of results still to issue
    // mask bits: up-left, up-here, row-left, row-here
    logic             s1_valid_reg;
    pixel_t           s1_px_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [3:0]       s1_mask_reg;
    logic [3:0]       s1_mask_next;
    logic             has_left;
    logic             has_up;

    assign has_left     = col_cnt_reg != '0;
    assign has_up       = row_cnt_reg != '0;
    assign s1_mask_next = {last_row && last_col, last_row && has_left,
                           has_up && last_col, has_up && has_left};

    pixel_t prev_pixel_reg;
    pixel_t prev_upper_reg;

    logic       s2_valid_reg;
    tap_set_t   s2_taps_reg;
    tap_set_t   s2_taps_next;
    logic       s2_ready;
    logic       s2_load;
    logic       s1_retire;
    logic [3:0] pick;
    logic [3:0] remaining;
    logic       sel_row;
    logic       sel_col;
    logic       dp_in_ready;

    assign pick      = s1_mask_reg & (~s1_mask_reg + 4'd1);
    assign remaining = s1_mask_reg & ~pick;
    assign sel_row   = pick[2] || pick[3];
    assign sel_col   = pick[1] || pick[3];

    assign s2_ready      = !s2_valid_reg || dp_in_ready;
    assign s2_load       = s1_valid_reg && (s1_mask_reg != '0) && s2_ready;
    assign s1_retire     = s1_valid_reg && ((s1_mask_reg == '0) || (s2_load && remaining == '0));
    assign s_axis_tready = !s1_valid_reg || s1_retire;

    // clamped neighbors collapse onto the current pixel
    always_comb begin
        if (sel_row) begin
            s2_taps_next.tl = sel_col ? s1_px_reg : prev_pixel_reg;
            s2_taps_next.tr = s1_px_reg;
            s2_taps_next.row = s1_row_reg;
        end else begin
            s2_taps_next.tl = sel_col ? above_reg : prev_upper_reg;
            s2_taps_next.tr = above_reg;
            s2_taps_next.row = s1_row_reg - ROW_W'(1);
        end
        s2_taps_next.bl   = sel_col ? s1_px_reg : prev_pixel_reg;
        s2_taps_next.br   = s1_px_reg;
        s2_taps_next.col  = sel_col ? COL_W'(s1_col_reg) : COL_W'(s1_col_reg - CW'(1));
        s2_taps_next.last = remaining == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            prev_pixel_reg <= '0;
            prev_upper_reg <= '0;
        end else begin
            if (s_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_retire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_load) begin
                s2_valid_reg <= 1'b1;
            end else if (dp_in_ready) begin
                s2_valid_reg <= 1'b0;
            end
            if (s1_retire) begin
                prev_pixel_reg <= s1_px_reg;
                prev_upper_reg <= above_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_px_reg   <= s_px;
            s1_col_reg  <= col_cnt_reg;
            s1_row_reg  <= row_cnt_reg;
            s1_mask_reg <= s1_mask_next;
        end else if (s2_load) begin
            s1_mask_reg <= remaining;
        end
        if (s2_load) begin
            s2_taps_reg <= s2_taps_next;
        end
    end

    pixel_t           out_pixel;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;

    saa_filter_dp #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_ready  (dp_in_ready),
        .in_taps   (s2_taps_reg),
        .coefs     (coef_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (out_pixel),
        .out_col   (out_col),
        .out_row   (out_row),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_row, out_col, out_pixel};

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> s1_valid_reg)
        else $error("accepted item did not reach the input stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_retire |=> s1_valid_reg && $stable(s1_px_reg))
        else $error("input stage lost its pixel before all results issued");

    a_prev_follows_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_retire |=> prev_pixel_reg == $past(s1_px_reg))
        else $error("left neighbor not updated on retire");

    a_last_means_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_load && s2_taps_next.last |-> s1_retire)
        else $error("last result issued while the pixel stays");

endmodule

`default_nettype wire

>>> sv/saa_filter_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module saa_filter_dp #(
    parameter int COEF_FRAC_BITS = saa_pkg::SAA_COEF_FRAC_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  saa_pkg::tap_set_t           in_taps,
    input  saa_pkg::coef_set_t          coefs,
    output logic                        out_valid,
    input  logic                        out_ready,
    output saa_pkg::pixel_t             out_pixel,
    output logic [saa_pkg::COL_W-1:0]   out_col,
    output logic [saa_pkg::ROW_W-1:0]   out_row,
    output logic                        out_last
);
    import saa_pkg::*;

    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NCH    = 3;
    localparam int NTAP   = 4;

    function automatic logic [PIX_W-1:0] chan_of(input pixel_t p, input int k);
        logic [PIX_W-1:0] c;
        case (k)
            0:       c = p.red;
            1:       c = p.green;
            default: c = p.blue;
        endcase
        return c;
    endfunction

    // negative sums clip to zero, the rest is truncated then limited to 255
    function automatic logic [PIX_W-1:0] saturate(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] q;
        logic [PIX_W-1:0] r;
        q = SUM_W'(s >>> COEF_FRAC_BITS);
        if (s[SUM_W-1]) begin
            r = '0;
        end else if (|q[SUM_W-1:PIX_W]) begin
            r = '1;
        end else begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

    logic                     p_valid_reg;
    logic signed [PROD_W-1:0] prod_reg  [NCH][NTAP];
    logic signed [PROD_W-1:0] prod_next [NCH][NTAP];
    logic [COL_W-1:0]         p_col_reg;
    logic [ROW_W-1:0]         p_row_reg;
    logic                     p_last_reg;

    logic                     o_valid_reg;
    pixel_t                   o_pixel_reg;
    pixel_t                   o_pixel_next;
    logic [COL_W-1:0]         o_col_reg;
    logic [ROW_W-1:0]         o_row_reg;
    logic                     o_last_reg;

    logic                     o_ready;
    logic                     p_ready;
    logic signed [SUM_W-1:0]  sums [NCH];

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_ready = p_ready;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            prod_next[k][0] = PROD_W'(coefs.tl * $signed({1'b0, chan_of(in_taps.tl, k)}));
            prod_next[k][1] = PROD_W'(coefs.tr * $signed({1'b0, chan_of(in_taps.tr, k)}));
            prod_next[k][2] = PROD_W'(coefs.bl * $signed({1'b0, chan_of(in_taps.bl, k)}));
            prod_next[k][3] = PROD_W'(coefs.br * $signed({1'b0, chan_of(in_taps.br, k)}));
        end
    end

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            sums[k] = SUM_W'(prod_reg[k][0]) + SUM_W'(prod_reg[k][1])
                    + SUM_W'(prod_reg[k][2]) + SUM_W'(prod_reg[k][3]);
        end
        o_pixel_next.red   = saturate(sums[0]);
        o_pixel_next.green = saturate(sums[1]);
        o_pixel_next.blue  = saturate(sums[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= in_valid;
            end
            if (o_ready) begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && p_ready) begin
            prod_reg   <= prod_next;
            p_col_reg  <= in_taps.col;
            p_row_reg  <= in_taps.row;
            p_last_reg <= in_taps.last;
        end
        if (p_valid_reg && o_ready) begin
            o_pixel_reg <= o_pixel_next;
            o_col_reg   <= p_col_reg;
            o_row_reg   <= p_row_reg;
            o_last_reg  <= p_last_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_pixel = o_pixel_reg;
    assign out_col   = o_col_reg;
    assign out_row   = o_row_reg;
    assign out_last  = o_last_reg;

endmodule

`default_nettype wire

>>> sim/supersample_antialias_filter_tb.sv
`timescale 1ns / 1ps

module supersample_antialias_filter_tb;
    import saa_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } out_pixel_t;

    typedef enum {COEF_KERNEL, COEF_WILD, COEF_EXTREME} coef_style_t;

    // indexes past the register file, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int     COL_LSB        = 3 * PIX_W;
    localparam int     ROW_LSB        = COL_LSB + COL_W;
    localparam int     CYCLE_LIMIT    = 1_000_000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     IDLE_MAX       = 10;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     RANDOM_ITEMS   = 300;
    localparam int     WIDE_RUN_ITEMS = 60;
    localparam int     MAX_REPORTS    = 100;
    localparam longint COEF_MIN       = -131072;
    localparam longint COEF_MAX       = 131071;
    localparam longint COEF_ONE       = 65536;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int cycle_count  = 0;
    int in_idle_max  = IDLE_MAX;
    int out_idle_max = IDLE_MAX;
    bit hold_request = 1'b0;

    class pixel_scoreboard;
        logic [WIDTH_REG_W-1:0]   width_reg;
        logic [HEIGHT_REG_W-1:0]  height_reg;
        logic signed [COEF_W-1:0] coef_tl;
        logic signed [COEF_W-1:0] coef_tr;
        logic signed [COEF_W-1:0] coef_bl;
        logic signed [COEF_W-1:0] coef_br;
        pixel_t                   line_mem [SAA_MAX_WIDTH];
        bit                       written [SAA_MAX_WIDTH];
        pixel_t                   left_px;
        pixel_t                   upper_left_px;
        int                       col;
        int                       row;
        out_pixel_t               pending_pixels [$];
        int                       mismatches;

        function new();
            width_reg     = RST_IMAGE_WIDTH;
            height_reg    = RST_IMAGE_HEIGHT;
            coef_tl       = RST_COEF_TL;
            coef_tr       = RST_COEF_OTHER;
            coef_bl       = RST_COEF_OTHER;
            coef_br       = RST_COEF_OTHER;
            left_px       = '0;
            upper_left_px = '0;
            col           = 0;
            row           = 0;
            mismatches    = 0;
            for (int i = 0; i < SAA_MAX_WIDTH; i++) begin
                line_mem[i] = '0;
                written[i]  = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
                REG_COEF_TL: coef_tl = data[COEF_W-1:0];
                REG_COEF_TR: coef_tr = data[COEF_W-1:0];
                REG_COEF_BL: coef_bl = data[COEF_W-1:0];
                REG_COEF_BR: coef_br = data[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_width(int v);
            if (v < 1) return 1;
            if (v > SAA_MAX_WIDTH) return SAA_MAX_WIDTH;
            return v;
        endfunction

        function int clamp_height(int v);
            if (v < 1) return 1;
            if (v > MAX_HEIGHT) return MAX_HEIGHT;
            return v;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        // true when every column below w has been written at least once
        function bit store_ready(int w);
            for (int i = 0; i < w; i++) begin
                if (!written[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function logic [PIX_W-1:0] blend_channel(pixel_t tl, pixel_t tr, pixel_t bl,
                                                 pixel_t br, int k);
            longint acc;
            acc = longint'(coef_tl) * longint'(tl[8*k +: 8])
                + longint'(coef_tr) * longint'(tr[8*k +: 8])
                + longint'(coef_bl) * longint'(bl[8*k +: 8])
                + longint'(coef_br) * longint'(br[8*k +: 8]);
            if (acc < 0) return '0;
            acc = acc >>> SAA_COEF_FRAC_BITS;
            if (acc > 255) return 8'd255;
            return acc[PIX_W-1:0];
        endfunction

        function void take_pixel(pixel_t px);
            int         w;
            int         h;
            int         x;
            int         y;
            int         ri;
            int         ci;
            int         n_before;
            bit         last_col;
            bit         last_row;
            pixel_t     above;
            pixel_t     tl;
            pixel_t     tr;
            pixel_t     bl;
            pixel_t     br;
            out_pixel_t res;
            w        = clamp_width(width_reg);
            h        = clamp_height(height_reg);
            x        = col;
            y        = row;
            above    = line_mem[x];
            last_col = x >= w - 1;
            last_row = y >= h - 1;
            n_before = pending_pixels.size();
            // upper pair of rows first, then the clamped bottom row
            for (ri = 0; ri < 2; ri++) begin
                if (ri == 0 && y < 1) continue;
                if (ri == 1 && !last_row) continue;
                for (ci = 0; ci < 2; ci++) begin
                    if (ci == 0 && x < 1) continue;
                    if (ci == 1 && !last_col) continue;
                    if (ri == 0) begin
                        tl = (ci == 0) ? upper_left_px : above;
                        tr = above;
                    end else begin
                        tl = (ci == 0) ? left_px : px;
                        tr = px;
                    end
                    bl = (ci == 0) ? left_px : px;
                    br = px;
                    res.red   = blend_channel(tl, tr, bl, br, 0);
                    res.green = blend_channel(tl, tr, bl, br, 1);
                    res.blue  = blend_channel(tl, tr, bl, br, 2);
                    res.col   = COL_W'((ci == 0) ? x - 1 : x);
                    res.row   = ROW_W'((ri == 0) ? y - 1 : y);
                    res.last  = 1'b0;
                    pending_pixels.push_back(res);
                end
            end
            if (pending_pixels.size() > n_before)
                pending_pixels[pending_pixels.size() - 1].last = 1'b1;

            upper_left_px = above;
            left_px       = px;
            line_mem[x]   = px;
            written[x]    = 1'b1;
            if (last_col) begin
                col = 0;
                row = last_row ? 0 : (y + 1) & 12'hFFF;
            end else begin
                col = (x + 1) & 10'h3FF;
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            // keep the log short when the design is badly off
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare_field(string name, int got, int want, out_pixel_t exp_px);
            if (got != want)
                flag_mismatch($sformatf("%s at column %0d row %0d: got %0d, expected %0d",
                                        name, exp_px.col, exp_px.row, got, want));
        endtask

        task check_pixel(logic [M_TDATA_W-1:0] tdata, logic tlast);
            out_pixel_t want;
            if (pending_pixels.size() == 0) begin
                flag_mismatch($sformatf("result at column %0d row %0d with nothing expected",
                                        tdata[COL_LSB +: COL_W], tdata[ROW_LSB +: ROW_W]));
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red", tdata[0 +: PIX_W], want.red, want);
            compare_field("green", tdata[PIX_W +: PIX_W], want.green, want);
            compare_field("blue", tdata[2*PIX_W +: PIX_W], want.blue, want);
            compare_field("column", tdata[COL_LSB +: COL_W], want.col, want);
            compare_field("row", tdata[ROW_LSB +: ROW_W], want.row, want);
            compare_field("tlast", tlast, want.last, want);
        endtask
    endclass

    pixel_scoreboard sb;

    supersample_antialias_filter DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(coef_style_t style);
        longint v;
        case (style)
            COEF_WILD: v = $urandom_range(0, 18'h3FFFF);
            COEF_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: v = COEF_MIN;
                    1: v = COEF_MAX;
                    2: v = 0;
                    3: v = COEF_ONE;
                    default: v = -1;
                endcase
            end
            default: begin
                // mostly a plausible kernel weight, now and then a small negative lobe
                if ($urandom_range(0, 7) == 0)
                    v = -longint'($urandom_range(0, 8192));
                else
                    v = $urandom_range(0, 40000);
            end
        endcase
        return v[COEF_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h, longint tl, longint tr, longint bl, longint br);
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom_range(0, 18'h3FFFF)));
        write_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(REG_COEF_TL, CFG_DATA_W'(tl));
        write_reg(REG_COEF_TR, CFG_DATA_W'(tr));
        write_reg(REG_COEF_BL, CFG_DATA_W'(bl));
        write_reg(REG_COEF_BR, CFG_DATA_W'(br));
        cfg_wen <= 1'b0;
    endtask

    task automatic send_pixel(pixel_t px);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        sb.take_pixel(px);
    endtask

    task automatic send_fixed(pixel_t seq [$]);
        foreach (seq[i]) send_pixel(seq[i]);
        s_axis_tvalid <= 1'b0;
    endtask

    // pause_at: after that item the sender waits until every result is out
    task automatic send_run(int count, int pause_at);
        pixel_t px;
        for (int i = 0; i < count; i++) begin
            px.red   = pick_channel();
            px.green = pick_channel();
            px.blue  = pick_channel();
            send_pixel(px);
            if (i == pause_at) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending_pixels.size() != 0);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_sink
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            gap = $urandom_range(0, out_idle_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin : stimulus
        int          random_items;
        int          count;
        int          w;
        int          h;
        int          we;
        int          he;
        int          frame;
        int          rem;
        coef_style_t style;
        sb            = new();
        random_items  = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_wen       <= 1'b0;
        cfg_index     <= REG_IMAGE_WIDTH;
        cfg_wdata     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: first row only, nothing comes out
        send_fixed('{24'h000000, 24'hFFFFFF, 24'h0F55AA});
        wait_idle();

        // width shrinks mid row: column 3 now counts as the last one
        set_frame(2, 3, COEF_MAX, COEF_MIN, COEF_ONE, -1);
        send_fixed('{24'hFFFFFF, 24'h00FF00, 24'hFF00FF, 24'h123456, 24'h017F80});
        wait_idle();

        // zero dimensions clamp to a 1x1 frame, all neighbors are the pixel itself
        set_frame(0, 0, COEF_ONE - 1, 1, 0, 0);
        send_fixed('{24'h000000, 24'hFFFFFF, 24'hC04080});
        wait_idle();

        // oversized width clamps to the full line, no early end of the row
        set_frame(2047, 0, 16384, 16384, 16384, 16384);
        send_run(WIDE_RUN_ITEMS, -1);
        wait_idle();

        // one pixel per row, oversized height
        set_frame(1, 8191, 40000, -20000, 30000, 20000);
        send_fixed('{24'h000000, 24'hFFFFFF, 24'h7F8001, 24'h80017F, 24'hFF00FF, 24'h00FF00});
        wait_idle();

        // back pressure: receiver holds off, sender keeps offering, then drains mid run
        in_idle_max  = 0;
        hold_request = 1'b1;
        set_frame(4, 6, 20000, 15000, 15000, 16000);
        send_run(48, 24);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            case ($urandom_range(0, 9))
                0: w = 0;
                1: w = 2047;
                2: w = $urandom_range(10, 1024);
                default: w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0: h = 0;
                1: h = 8191;
                2: h = $urandom_range(8, 40);
                default: h = $urandom_range(1, 5);
            endcase
            we = sb.clamp_width(w);
            // a mid frame width change must not expose never-written line entries
            if (!sb.at_frame_start() && we != sb.clamp_width(sb.width_reg)
                    && !sb.store_ready(we)) begin
                w  = sb.width_reg;
                we = sb.clamp_width(w);
            end
            he = sb.clamp_height(h);
            case ($urandom_range(0, 4))
                3: style = COEF_WILD;
                4: style = COEF_EXTREME;
                default: style = COEF_KERNEL;
            endcase
            set_frame(w, h, pick_coef(style), pick_coef(style), pick_coef(style),
                      pick_coef(style));
            frame = we * he;
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, 20);
            end else if (frame > 60) begin
                count = $urandom_range(1, 40);
            end else begin
                // finish the frame in progress, then whole frames
                if (sb.row < he && sb.col < we)
                    rem = frame - sb.row * we - sb.col;
                else
                    rem = 0;
                count = rem + frame * $urandom_range(0, 2);
                if (count == 0) count = frame;
            end
            send_run(count, -1);
            wait_idle();
            random_items += count;
        end

        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
